### sv/cinv_pkg.sv
// ============================================================================
// cinv_pkg
// Shared types and constants for the circle inversion core.
// ============================================================================
`default_nettype none

package cinv_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QUO_BITS      = 32;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam logic [15:0] TOL_RST = 16'd655;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_E1  = 3'd0,
        CFG_E2  = 3'd1,
        CFG_E4  = 3'd2,
        CFG_E5  = 3'd3,
        CFG_TOL = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic        [30:0] radius;
    } t_in;

    typedef struct packed {
        logic signed [31:0] new_center_x;
        logic signed [31:0] new_center_y;
        logic        [30:0] new_radius;
        logic               is_line;
        logic               orthogonal;
        logic               overflow;
    } t_out;

    // flags that ride alongside the divider
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic line;
        logic orth;
    } t_side;

endpackage

`default_nettype wire

### sv/circle_inversion_inversive_coords_core.sv
// ============================================================================
// circle_inversion_inversive_coords_core
// Reflects a planar circle in a configured inverter circle in inversive
// coordinates and converts back to centre and radius, rounded and saturated.
// ============================================================================
// Pipeline: 8 arithmetic stages, 32 divider stages and 1 output stage from
// start to done. Throughput: one transaction per cycle, busy is never
// raised; the quotient pipeline sets the depth.
// Reset clears the valid chain and loads the unit-circle inverter and the
// default tolerance. The receiver cannot stall; done is a one-cycle strobe.
`default_nettype none

module circle_inversion_inversive_coords_core #(
    parameter int FRAC_BITS = cinv_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    output logic                                   o_busy,
    input  wire cinv_pkg::t_in                     i_cmd,
    input  wire logic                              i_cfg_we,
    input  wire logic [cinv_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  wire logic [cinv_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output logic                                   o_done,
    output cinv_pkg::t_out                         o_result
);

    import cinv_pkg::*;

    localparam int NB  = 98;                 // scalar product numerator
    localparam int MB  = 132;                // K' numerator and centre terms
    localparam int DW  = MB + FRAC_BITS + 2; // divider operands
    localparam int QB  = QUO_BITS;
    localparam int PRE = 8;
    localparam int LAT = PRE + QB;
    localparam logic signed [31:0] V4_RST = -(32'sd1 <<< FRAC_BITS);

    // ---------------- configuration ----------------
    logic signed [31:0] r_v1, r_v2, r_v4, r_v5;
    logic        [15:0] r_tol;
    logic signed [32:0] r_dv, r_sv, r_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= '0;
            r_v2  <= '0;
            r_v4  <= V4_RST;
            r_v5  <= '0;
            r_tol <= TOL_RST;
            r_dv  <= {V4_RST[31], V4_RST};
            r_sv  <= {V4_RST[31], V4_RST};
            r_w   <= -{V4_RST[31], V4_RST};
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_E1:  r_v1  <= i_cfg_data;
                    CFG_E2:  r_v2  <= i_cfg_data;
                    CFG_E4:  r_v4  <= i_cfg_data;
                    CFG_E5:  r_v5  <= i_cfg_data;
                    CFG_TOL: r_tol <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            // derived terms are registered from the config registers; first use is in S3
            r_dv <= {r_v4[31], r_v4} - {r_v5[31], r_v5};
            r_sv <= {r_v4[31], r_v4} + {r_v5[31], r_v5};
            r_w  <= {r_v5[31], r_v5} - {r_v4[31], r_v4};
        end
    end

    // ---------------- valid chain ----------------
    logic [LAT-1:0] r_vld;
    logic           r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[LAT-2:0], i_start};
            r_done <= r_vld[LAT-1];
        end
    end

    // ---------------- datapath ----------------
    logic signed [31:0] r1_x, r1_y;
    logic        [30:0] r1_r;
    logic signed [63:0] r1_xx, r1_yy, r1_xv1, r1_yv2;
    logic        [61:0] r1_rr;
    logic        [46:0] r1_tr;

    logic signed [31:0] r2_x, r2_y;
    logic        [30:0] r2_r;
    logic        [46:0] r2_tr;
    logic signed [65:0] r2_a;
    logic signed [64:0] r2_p;

    logic signed [31:0] r3_x, r3_y;
    logic        [30:0] r3_r;
    logic        [46:0] r3_tr;
    logic signed [64:0] r3_p;
    logic signed [66:0] r3_mh;
    logic signed [65:0] r3_ml;

    logic signed [31:0] r4_x, r4_y;
    logic        [30:0] r4_r;
    logic        [46:0] r4_tr;
    logic signed [NB-1:0] r4_n;

    logic signed [31:0] r5_x, r5_y;
    logic        [30:0] r5_r;
    logic               r5_orth;
    logic signed [66:0] r5_pw [3];
    logic signed [66:0] r5_px [3];
    logic signed [66:0] r5_py [3];

    logic        [30:0] r6_r;
    logic               r6_orth;
    logic signed [MB-1:0] r6_m, r6_ix, r6_iy;

    logic        [30:0] r7_r;
    logic        [MB-1:0] r7_am, r7_ax, r7_ay;
    t_side              r7_side;

    logic        [DW-1:0] r8_nx, r8_ny, r8_nr, r8_den;
    t_side              r8_side;

    t_side              r_sd [QB];

    logic        [30:0] s1_r;
    logic signed [33:0] s3_ah;
    logic signed [32:0] s3_al;
    logic signed [33:0] s5_l [3];
    logic        [NB-1:0] s5_abs, s5_lim;
    logic signed [MB-1:0] s6_nw, s6_nx, s6_ny;

    assign s1_r  = (i_cmd.radius == '0) ? 31'd1 : i_cmd.radius;
    assign s3_ah = r2_a[65:32];
    assign s3_al = {1'b0, r2_a[31:0]};
    assign s5_l[0] = {2'b00, r4_n[31:0]};
    assign s5_l[1] = {2'b00, r4_n[63:32]};
    assign s5_l[2] = r4_n[NB-1:64];
    assign s5_abs  = r4_n[NB-1] ? NB'(-r4_n) : NB'(r4_n);
    assign s5_lim  = NB'(r4_tr) << (FRAC_BITS + 1);

    always_comb begin
        s6_nw = (MB'(r5_pw[2]) <<< 64) + (MB'(r5_pw[1]) <<< 32) + MB'(r5_pw[0]);
        s6_nx = (MB'(r5_px[2]) <<< 64) + (MB'(r5_px[1]) <<< 32) + MB'(r5_px[0]);
        s6_ny = (MB'(r5_py[2]) <<< 64) + (MB'(r5_py[1]) <<< 32) + MB'(r5_py[0]);
    end

    always_ff @(posedge i_clk) begin
        // S1: squares and first products
        r1_x   <= i_cmd.center_x;
        r1_y   <= i_cmd.center_y;
        r1_r   <= s1_r;
        r1_xx  <= i_cmd.center_x * i_cmd.center_x;
        r1_yy  <= i_cmd.center_y * i_cmd.center_y;
        r1_rr  <= s1_r * s1_r;
        r1_xv1 <= i_cmd.center_x * r_v1;
        r1_yv2 <= i_cmd.center_y * r_v2;
        r1_tr  <= r_tol * s1_r;

        // S2: A = |c|^2 - r^2, P = x*v1 + y*v2
        r2_x  <= r1_x;
        r2_y  <= r1_y;
        r2_r  <= r1_r;
        r2_tr <= r1_tr;
        r2_a  <= 66'(r1_xx) + 66'(r1_yy) - $signed({4'b0000, r1_rr});
        r2_p  <= 65'(r1_xv1) + 65'(r1_yv2);

        // S3: A*(v4-v5) in two halves
        r3_x  <= r2_x;
        r3_y  <= r2_y;
        r3_r  <= r2_r;
        r3_tr <= r2_tr;
        r3_p  <= r2_p;
        r3_mh <= s3_ah * r_dv;
        r3_ml <= s3_al * r_dv;

        // S4: scalar product numerator
        r4_x  <= r3_x;
        r4_y  <= r3_y;
        r4_r  <= r3_r;
        r4_tr <= r3_tr;
        r4_n  <= (NB'(r3_mh) <<< 32) + NB'(r3_ml)
               + (NB'(r3_p) <<< (FRAC_BITS + 1))
               - (NB'(r_sv) <<< (2 * FRAC_BITS));

        // S5: limb products of N, orthogonality test
        r5_x    <= r4_x;
        r5_y    <= r4_y;
        r5_r    <= r4_r;
        r5_orth <= s5_abs < s5_lim;
        for (int i = 0; i < 3; i++) begin
            r5_pw[i] <= s5_l[i] * r_w;
            r5_px[i] <= s5_l[i] * r_v1;
            r5_py[i] <= s5_l[i] * r_v2;
        end

        // S6: M = S^4 - N*W and centre numerators
        r6_r    <= r5_r;
        r6_orth <= r5_orth;
        r6_m    <= (MB'(1) <<< (4 * FRAC_BITS)) - s6_nw;
        r6_ix   <= (MB'(r5_x) <<< (3 * FRAC_BITS)) - s6_nx;
        r6_iy   <= (MB'(r5_y) <<< (3 * FRAC_BITS)) - s6_ny;

        // S7: magnitudes and signs
        r7_r  <= r6_r;
        r7_am <= r6_m[MB-1]  ? MB'(-r6_m)  : MB'(r6_m);
        r7_ax <= r6_ix[MB-1] ? MB'(-r6_ix) : MB'(r6_ix);
        r7_ay <= r6_iy[MB-1] ? MB'(-r6_iy) : MB'(r6_iy);
        r7_side.neg_x <= r6_ix[MB-1] ^ r6_m[MB-1];
        r7_side.neg_y <= r6_iy[MB-1] ^ r6_m[MB-1];
        r7_side.line  <= (r6_m == '0);
        r7_side.orth  <= r6_orth;

        // S8: round-to-nearest operands, 2n + d over 2d
        r8_nx   <= (DW'(r7_ax) << (FRAC_BITS + 1)) + DW'(r7_am);
        r8_ny   <= (DW'(r7_ay) << (FRAC_BITS + 1)) + DW'(r7_am);
        r8_nr   <= (DW'(r7_r) << (4 * FRAC_BITS + 1)) + DW'(r7_am);
        r8_den  <= DW'(r7_am) << 1;
        r8_side <= r7_side;

        r_sd[0] <= r8_side;
        for (int k = 1; k < QB; k++) begin
            r_sd[k] <= r_sd[k-1];
        end
    end

    // ---------------- dividers ----------------
    logic [QB-1:0] s_qx, s_qy, s_qr;
    logic          s_bx, s_by, s_br;

    cinv_pdiv #(.W(DW), .QB(QB)) u_div_x (
        .i_clk (i_clk), .i_num (r8_nx), .i_den (r8_den), .o_q (s_qx), .o_big (s_bx)
    );
    cinv_pdiv #(.W(DW), .QB(QB)) u_div_y (
        .i_clk (i_clk), .i_num (r8_ny), .i_den (r8_den), .o_q (s_qy), .o_big (s_by)
    );
    cinv_pdiv #(.W(DW), .QB(QB)) u_div_r (
        .i_clk (i_clk), .i_num (r8_nr), .i_den (r8_den), .o_q (s_qr), .o_big (s_br)
    );

    // {saturated, signed value}
    function automatic logic [32:0] f_sat(input logic [QB-1:0] q, input logic big,
                                          input logic neg);
        logic        sat;
        logic [31:0] mag;
        sat = big || (neg ? (q > 32'h8000_0000) : q[31]);
        mag = sat ? (neg ? 32'h8000_0000 : 32'h7FFF_FFFF) : q;
        return {sat, (neg ? (~mag + 32'd1) : mag)};
    endfunction

    logic [32:0] s_fx, s_fy;
    logic        s_rsat;
    t_out        n_res, r_res;
    t_side       s_side;

    assign s_side = r_sd[QB-1];
    assign s_fx   = f_sat(s_qx, s_bx, s_side.neg_x);
    assign s_fy   = f_sat(s_qy, s_by, s_side.neg_y);
    assign s_rsat = s_br || s_qr[QB-1];

    always_comb begin
        n_res.orthogonal = s_side.orth;
        if (s_side.line) begin
            n_res.new_center_x = '0;
            n_res.new_center_y = '0;
            n_res.new_radius   = '0;
            n_res.is_line      = 1'b1;
            n_res.overflow     = 1'b0;
        end else begin
            n_res.new_center_x = s_fx[31:0];
            n_res.new_center_y = s_fy[31:0];
            n_res.new_radius   = s_rsat ? 31'h7FFF_FFFF : s_qr[30:0];
            n_res.is_line      = 1'b0;
            n_res.overflow     = s_fx[32] || s_fy[32] || s_rsat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_busy   = 1'b0;
    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef SYNTH
    a_line_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.is_line |-> o_result.new_radius == '0
            && o_result.new_center_x == '0 && o_result.new_center_y == '0)
        else $error("line result with nonzero geometry");
    a_line_novf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.is_line |-> !o_result.overflow)
        else $error("overflow flagged on line result");
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("done strobe straight after reset");
`endif

endmodule

`default_nettype wire

### sv/cinv_pdiv.sv
// ============================================================================
// cinv_pdiv
// Pipelined restoring divider, one quotient bit per stage, with a flag for
// quotients that do not fit in the quotient width.
// ============================================================================
`default_nettype none

module cinv_pdiv #(
    parameter int W  = 150,
    parameter int QB = 32
) (
    input  wire logic          i_clk,
    input  wire logic [W-1:0]  i_num,
    input  wire logic [W-1:0]  i_den,
    output logic      [QB-1:0] o_q,
    output logic               o_big
);

    logic [W+QB-1:0] r_rem [QB];
    logic [W-1:0]    r_den [QB];
    logic [QB-1:0]   r_q   [QB];
    logic            r_big [QB];

    logic [W+QB-1:0] s_rem [QB+1];
    logic [W-1:0]    s_den [QB+1];
    logic [QB-1:0]   s_q   [QB+1];
    logic            s_big [QB+1];

    always_comb begin
        s_rem[0] = {{QB{1'b0}}, i_num};
        s_den[0] = i_den;
        s_q[0]   = '0;
        s_big[0] = {{QB{1'b0}}, i_num} >= {i_den, {QB{1'b0}}};
        for (int k = 0; k < QB; k++) begin
            s_rem[k+1] = r_rem[k];
            s_den[k+1] = r_den[k];
            s_q[k+1]   = r_q[k];
            s_big[k+1] = r_big[k];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QB; k++) begin
            logic [W+QB-1:0] sh;
            sh = {{QB{1'b0}}, s_den[k]} << (QB - 1 - k);
            if (s_rem[k] >= sh) begin
                r_rem[k] <= s_rem[k] - sh;
                r_q[k]   <= s_q[k] | (QB'(1) << (QB - 1 - k));
            end else begin
                r_rem[k] <= s_rem[k];
                r_q[k]   <= s_q[k];
            end
            r_den[k] <= s_den[k];
            r_big[k] <= s_big[k];
        end
    end

    assign o_q   = r_q[QB-1];
    assign o_big = r_big[QB-1];

endmodule

`default_nettype wire

### test/tb_circle_inversion_inversive_coords_core.sv
// ----------------------------------------------------------------------------
// tb_circle_inversion_inversive_coords_core
// Streams circles through the inversion core in bursts under several inverter
// settings and checks every result against an exact wide-integer predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_circle_inversion_inversive_coords_core;
    import cinv_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 60;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    t_in         i_cmd = '0;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic        o_done;
    t_out        o_result;

    circle_inversion_inversive_coords_core #(.FRAC_BITS(FRAC)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_cmd(i_cmd), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_done(o_done), .o_result(o_result)
    );

    always #6 i_clk = ~i_clk;

    typedef logic signed [255:0] t_wide;

    // local copy of the inverter registers
    logic signed [31:0] inv_e1 = 0, inv_e2 = 0, inv_e4 = -(1 <<< FRAC), inv_e5 = 0;
    logic [15:0] tol = TOL_RST;

    t_in  pending_circles[$];
    t_out expected_images[$];
    int   errors = 0;
    int   cycles = 0;
    int   burst_left = 4;
    int   gap_left = 0;

    function automatic t_wide sx(logic signed [31:0] v);
        return {{224{v[31]}}, v};
    endfunction

    function automatic t_wide mag(t_wide v);
        return (v < 0) ? -v : v;
    endfunction

    // nearest, ties away from zero, clamped to 32 bit signed
    function automatic logic [31:0] round_div(t_wide num, t_wide den, inout logic ovf);
        logic  neg;
        t_wide q, lim;
        neg = (num < 0) != (den < 0);
        q = (2 * mag(num) + mag(den)) / (2 * mag(den));
        lim = neg ? (t_wide'(1) <<< 31) : ((t_wide'(1) <<< 31) - 1);
        if (q > lim) begin
            q = lim;
            ovf = 1'b1;
        end
        if (neg) q = -q;
        return q[31:0];
    endfunction

    function automatic t_out invert_circle(t_in c);
        t_wide x, y, r, s, s2, s3, s4, a, n, d, m, w, nx, ny, nr, am, q;
        t_wide e1, e2, e4, e5;
        t_out  o;
        logic  ovf;
        ovf = 1'b0;
        o = '0;
        x = sx(c.center_x);
        y = sx(c.center_y);
        r = {225'b0, c.radius};
        if (r == 0) r = 1;
        e1 = sx(inv_e1); e2 = sx(inv_e2); e4 = sx(inv_e4); e5 = sx(inv_e5);
        s = t_wide'(1) <<< FRAC;
        s2 = s * s; s3 = s2 * s; s4 = s3 * s;
        a = x * x + y * y - r * r;
        n = 2 * s * (x * e1 + y * e2) + (a - s2) * e4 - (a + s2) * e5;
        d = 2 * s2 * r;
        o.orthogonal = (mag(n) * s) < ({240'b0, tol} * d);
        w = e5 - e4;
        m = s4 - n * w;
        if (m == 0) begin
            o.is_line = 1'b1;
        end else begin
            nx = s * (s3 * x - n * e1);
            ny = s * (s3 * y - n * e2);
            am = mag(m);
            nr = s4 * r;
            q = (2 * nr + am) / (2 * am);
            o.new_center_x = round_div(nx, m, ovf);
            o.new_center_y = round_div(ny, m, ovf);
            if (q > 256'h7FFF_FFFF) begin
                q = 256'h7FFF_FFFF;
                ovf = 1'b1;
            end
            o.new_radius = q[30:0];
        end
        o.overflow = ovf;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // driver: bursts with random gaps
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_start && !o_busy) expected_images.push_back(invert_circle(i_cmd));
            if (i_start && o_busy) begin
                // hold the transaction
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_start <= 1'b0;
            end else if (pending_circles.size() > 0) begin
                i_cmd <= pending_circles.pop_front();
                i_start <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_done) begin
            if (expected_images.size() == 0) begin
                report_mismatch("unexpected result", 32'd0, 32'd0);
            end else begin
                want = expected_images.pop_front();
                if (o_result.new_center_x !== want.new_center_x)
                    report_mismatch("new_center_x", o_result.new_center_x, want.new_center_x);
                if (o_result.new_center_y !== want.new_center_y)
                    report_mismatch("new_center_y", o_result.new_center_y, want.new_center_y);
                if (o_result.new_radius !== want.new_radius)
                    report_mismatch("new_radius", 32'(o_result.new_radius),
                                    32'(want.new_radius));
                if (o_result.is_line !== want.is_line)
                    report_mismatch("is_line", 32'(o_result.is_line), 32'(want.is_line));
                if (o_result.orthogonal !== want.orthogonal)
                    report_mismatch("orthogonal", 32'(o_result.orthogonal),
                                    32'(want.orthogonal));
                if (o_result.overflow !== want.overflow)
                    report_mismatch("overflow", 32'(o_result.overflow), 32'(want.overflow));
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > LIMIT_CYCLES) begin
            $display("FAIL circle_inversion_inversive_coords_core");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [31:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        case (idx)
            CFG_E1:  inv_e1 = v;
            CFG_E2:  inv_e2 = v;
            CFG_E4:  inv_e4 = v;
            CFG_E5:  inv_e5 = v;
            CFG_TOL: tol = v[15:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_inverter(logic [31:0] e1, logic [31:0] e2, logic [31:0] e4,
                                logic [31:0] e5, logic [15:0] t);
        write_reg(CFG_E1, e1);
        write_reg(CFG_E2, e2);
        write_reg(CFG_E4, e4);
        write_reg(CFG_E5, e5);
        write_reg(CFG_TOL, {16'b0, t});
    endtask

    // radius arrives 32 bits wide and keeps its low 31
    function automatic t_in mk(logic [31:0] cx, logic [31:0] cy, logic [31:0] r);
        t_in c;
        c.center_x = cx;
        c.center_y = cy;
        c.radius = r[30:0];
        return c;
    endfunction

    function automatic logic [31:0] small_val(int range_bits);
        logic [31:0] v;
        v = $urandom_range(0, (1 << range_bits) - 1);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    task automatic queue_random(int count);
        t_in c;
        repeat (count) begin
            if ($urandom_range(0, 9) == 0) begin
                c = mk($urandom, $urandom, $urandom);
            end else begin
                c = mk(small_val($urandom_range(4, 22)), small_val($urandom_range(4, 22)),
                       $urandom_range(1, 1 << $urandom_range(2, 22)));
            end
            pending_circles.push_back(c);
        end
    endtask

    task automatic drain;
        while (pending_circles.size() > 0 || i_start || expected_images.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    localparam logic [31:0] ONE = 32'd1 << FRAC;

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset inverter: unit circle
        pending_circles.push_back(mk(ONE, 0, ONE));              // through the centre: line
        pending_circles.push_back(mk(0, 0, ONE));                 // the inverter itself
        pending_circles.push_back(mk(0, 0, 32'd0));               // zero radius
        pending_circles.push_back(mk(0, 0, 32'd1));
        pending_circles.push_back(mk(0, 0, 32'h7FFF_FFFF));       // tiny image radius
        pending_circles.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1));
        pending_circles.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'd1));
        pending_circles.push_back(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        pending_circles.push_back(mk(2 * ONE, 0, ONE));
        pending_circles.push_back(mk(-2 * ONE, 0, 3 * ONE));
        pending_circles.push_back(mk(0, ONE + 1, ONE));           // near line: overflow
        pending_circles.push_back(mk(ONE, ONE, ONE));
        pending_circles.push_back(mk(32'd113512, 0, 32'd92682)); // near orthogonal
        pending_circles.push_back(mk(0, 32'hFFFF_FFFF, 32'd2));
        queue_random(65);
        drain();

        set_inverter(0, 0, -ONE, 0, 16'hFFFF);
        queue_random(65);
        drain();

        set_inverter(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0);
        queue_random(65);
        drain();

        set_inverter(ONE, 0, ONE / 2, 3 * ONE / 2, TOL_RST);     // shifted unit circle
        pending_circles.push_back(mk(ONE, 0, ONE));
        queue_random(65);
        drain();

        repeat (2) begin
            set_inverter(small_val(18), small_val(18), small_val(18), small_val(18),
                         16'($urandom_range(0, 65535)));
            queue_random(65);
            drain();
        end

        set_inverter($urandom, $urandom, $urandom, $urandom, 16'($urandom));
        queue_random(30);
        drain();

        if (errors == 0) begin
            $display("PASS circle_inversion_inversive_coords_core");
        end else begin
            $display("FAIL circle_inversion_inversive_coords_core");
        end
        $finish;
    end

endmodule
